### rtl/fpdf_pkg.sv
package fpdf_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;

    localparam logic [3:0] CAP_UNSIGNED = 4'd10;
    localparam logic [3:0] CAP_SIGNED   = 4'd11;
    localparam logic [3:0] CAP_FIXED    = 4'd13;
    localparam logic [2:0] MAX_DEC      = 3'd4;

    localparam logic [5:0] CHAR_SPACE = 6'h20;
    localparam logic [5:0] CHAR_MINUS = 6'h2D;
    localparam logic [5:0] CHAR_DOT   = 6'h2E;
    localparam logic [5:0] CHAR_ZERO  = 6'h30;
    localparam logic [5:0] CHAR_NINE  = 6'h39;

endpackage

### rtl/fixed_point_decimal_formatter.sv
// Formats one 32-bit value as right-aligned decimal ASCII text, most significant character
// first, one character per output request with m_last on the final one. An input request is
// taken only while the block is idle. The magnitude is converted to BCD one bit per cycle by a
// bit-serial binary to BCD converter, then leading zero digits are dropped one per cycle, then
// the characters are emitted, each one taken while m_ready is high.
module fixed_point_decimal_formatter
    import fpdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [VALUE_W-1:0] s_value,
    input  logic [3:0]         s_decimals,
    input  logic [3:0]         s_pad_width,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_out_char,
    output logic [3:0]         m_char_pos,
    output logic               m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_ALIGN,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [VALUE_W-1:0]   mag_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BCD_W-1:0]     bcd_next;
    logic [3:0]           rem_reg;
    logic [2:0]           dec_reg;
    logic                 neg_reg;
    logic                 dot_reg;
    logic [3:0]           cap_reg;
    logic [3:0]           width_reg;
    logic [3:0]           pad_reg;
    logic [3:0]           pos_reg;

    logic                 in_neg;
    logic [2:0]           in_dec;
    logic [3:0]           in_cap;
    logic [3:0]           min_dig;
    logic [3:0]           pw_eff;
    logic [3:0]           core_len;
    logic [3:0]           top_digit;
    logic                 at_dot;
    logic                 at_digit;

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
        bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
    end

    always_comb begin
        in_neg = (s_mode != MODE_UNSIGNED) && s_value[VALUE_W-1];
        if (!s_mode[1]) begin
            in_dec = 3'd0;
        end else if (s_decimals > {1'b0, MAX_DEC}) begin
            in_dec = MAX_DEC;
        end else begin
            in_dec = s_decimals[2:0];
        end
        case (s_mode)
            MODE_UNSIGNED: in_cap = CAP_UNSIGNED;
            MODE_SIGNED:   in_cap = CAP_SIGNED;
            default:       in_cap = CAP_FIXED;
        endcase
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign min_dig   = {1'b0, dec_reg} + 4'd1;
    assign pw_eff    = (width_reg > cap_reg) ? cap_reg : width_reg;
    assign core_len  = rem_reg + {3'd0, dot_reg} + {3'd0, neg_reg};

    assign at_dot   = (pad_reg == 4'd0) && !neg_reg && dot_reg && (rem_reg == {1'b0, dec_reg});
    assign at_digit = (pad_reg == 4'd0) && !neg_reg && !at_dot;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_EMIT);
    assign m_char_pos = pos_reg;
    assign m_last     = at_digit && (rem_reg == 4'd1);

    always_comb begin
        if (pad_reg != 4'd0) begin
            m_out_char = CHAR_SPACE;
        end else if (neg_reg) begin
            m_out_char = CHAR_MINUS;
        end else if (at_dot) begin
            m_out_char = CHAR_DOT;
        end else begin
            m_out_char = CHAR_ZERO + {2'b00, top_digit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            rem_reg     <= '0;
            pad_reg     <= '0;
            pos_reg     <= '0;
            neg_reg     <= 1'b0;
            dot_reg     <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mag_reg     <= in_neg ? (~s_value + 1'b1) : s_value;
                        bcd_reg     <= '0;
                        neg_reg     <= in_neg;
                        dec_reg     <= in_dec;
                        dot_reg     <= (in_dec != 3'd0);
                        cap_reg     <= in_cap;
                        width_reg   <= s_pad_width;
                        bit_cnt_reg <= '0;
                        pos_reg     <= '0;
                        state_reg   <= ST_CONVERT;
                    end
                end
                ST_CONVERT: begin
                    bcd_reg     <= bcd_next;
                    mag_reg     <= {mag_reg[VALUE_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                        rem_reg   <= 4'(NUM_DIGITS);
                        state_reg <= ST_ALIGN;
                    end
                end
                ST_ALIGN: begin
                    // drop leading zeros, keeping the fraction digits and one integer digit
                    if (top_digit == 4'd0 && rem_reg > min_dig) begin
                        bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
                        rem_reg <= rem_reg - 4'd1;
                    end else begin
                        pad_reg   <= (pw_eff > core_len) ? (pw_eff - core_len) : 4'd0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        pos_reg <= pos_reg + 4'd1;
                        if (pad_reg != 4'd0) begin
                            pad_reg <= pad_reg - 4'd1;
                        end else if (neg_reg) begin
                            neg_reg <= 1'b0;
                        end else if (at_dot) begin
                            dot_reg <= 1'b0;
                        end else begin
                            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
                            rem_reg <= rem_reg - 4'd1;
                            if (rem_reg == 4'd1) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_char == CHAR_SPACE || m_out_char == CHAR_MINUS ||
                     m_out_char == CHAR_DOT ||
                     (m_out_char >= CHAR_ZERO && m_out_char <= CHAR_NINE)))
        else $error("illegal character on output");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
            (m_valid && m_char_pos == $past(m_char_pos) + 4'd1))
        else $error("text broken before last character");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid))
        else $error("block not idle after last character");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("accepted request not converting");

    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (rem_reg != 4'd0 && rem_reg <= 4'(NUM_DIGITS)))
        else $error("digit count out of range while emitting");
`endif

endmodule

### test/tb_fixed_point_decimal_formatter.sv
module tb_fixed_point_decimal_formatter
    import fpdf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_FIXED     = 2'd2;
    localparam logic [1:0] MODE_FIXED_ALT = 2'd3;
    localparam int TEXT_SIG_DIGITS  = 10;
    localparam int FIXED_TEXT_LIMIT = 12;
    localparam int NUM_RANDOM       = 200;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 80;

    typedef struct packed {
        logic [5:0] out_char;
        logic [3:0] char_pos;
        logic       last;
    } text_char_t;

    class text_scoreboard;
        text_char_t expected_chars[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // builds the text low end first, then queues it most significant first
        function void note_request(logic [1:0] mode, logic [31:0] value,
                                   logic [3:0] decimals, logic [3:0] pad_width);
            logic [5:0]  rev[$];
            logic [31:0] mag;
            logic        neg;
            int          fracs;
            int          cap;
            int          k;
            text_char_t  c;
            mag = value;
            neg = 1'b0;
            if (mode != MODE_UNSIGNED) begin
                neg = value[31];
                if (neg) mag = -value;
            end
            if (mode[1]) begin
                cap = int'(CAP_FIXED);
                fracs = (decimals > MAX_DEC) ? int'(MAX_DEC) : int'(decimals);
                repeat (fracs) begin
                    rev.push_back(CHAR_ZERO + 6'(mag % 10));
                    mag = mag / 10;
                end
                if (fracs > 0) rev.push_back(CHAR_DOT);
                do begin
                    rev.push_back(CHAR_ZERO + 6'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0 && rev.size() < FIXED_TEXT_LIMIT);
            end else begin
                cap = (mode == MODE_UNSIGNED) ? int'(CAP_UNSIGNED) : int'(CAP_SIGNED);
                do begin
                    rev.push_back(CHAR_ZERO + 6'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0 && rev.size() < TEXT_SIG_DIGITS);
            end
            if (neg && rev.size() < cap) rev.push_back(CHAR_MINUS);
            while (rev.size() < int'(pad_width) && rev.size() < cap) rev.push_back(CHAR_SPACE);
            for (k = 0; k < rev.size(); k++) begin
                c.out_char = rev[rev.size() - 1 - k];
                c.char_pos = 4'(k);
                c.last     = (k == rev.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [5:0] out_char, logic [3:0] char_pos, logic last);
            text_char_t e;
            if (expected_chars.size() == 0) begin
                $error("unexpected character %0h at position %0d", out_char, char_pos);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            if (out_char !== e.out_char) begin
                $error("out_char: expected %0h, got %0h", e.out_char, out_char);
                errors++;
            end
            if (char_pos !== e.char_pos) begin
                $error("char_pos: expected %0d, got %0d", e.char_pos, char_pos);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [31:0] s_value;
    logic [3:0]  s_decimals;
    logic [3:0]  s_pad_width;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_out_char;
    logic [3:0]  m_char_pos;
    logic        m_last;

    text_scoreboard sb;
    bit hold_off_req = 1'b0;
    int idle_cycles  = 0;

    fixed_point_decimal_formatter i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .s_decimals  (s_decimals),
        .s_pad_width (s_pad_width),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_char_pos  (m_char_pos),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 99999);
            2: return -$urandom_range(1, 99999);
            3: return 32'h8000_0000 + $urandom_range(0, 3);
            4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            5: return 32'hFFFF_FFFF - $urandom_range(0, 9);
            6: return $urandom_range(999999990, 1000000009);
            default: return $urandom;
        endcase
    endfunction

    task automatic drive_request(input logic [1:0] mode, input logic [31:0] value,
                                 input logic [3:0] decimals, input logic [3:0] pad_width);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_value     <= value;
        s_decimals  <= decimals;
        s_pad_width <= pad_width;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin : receiver
        int burst;
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                // long hold-off so the block stays busy and stalls its input
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            burst = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
            m_ready <= 1'b1;
            repeat (burst) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_mode, s_value, s_decimals, s_pad_width);
            if (m_valid && m_ready) sb.check_char(m_out_char, m_char_pos, m_last);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int i;
        sb = new();
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_mode      <= MODE_UNSIGNED;
        s_value     <= '0;
        s_decimals  <= '0;
        s_pad_width <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unsigned extremes and width saturation
        drive_request(MODE_UNSIGNED, 32'd0, 4'd0, 4'd0);
        drive_request(MODE_UNSIGNED, 32'hFFFF_FFFF, 4'd15, 4'd15);
        drive_request(MODE_UNSIGNED, 32'd1, 4'd9, 4'd15);
        drive_request(MODE_UNSIGNED, 32'd1000000000, 4'd0, 4'd10);
        // signed: most negative value, minus one, largest positive, zero, minus 42
        drive_request(MODE_SIGNED, 32'h8000_0000, 4'd0, 4'd15);
        drive_request(MODE_SIGNED, 32'hFFFF_FFFF, 4'd15, 4'd0);
        drive_request(MODE_SIGNED, 32'h7FFF_FFFF, 4'd3, 4'd11);
        drive_request(MODE_SIGNED, 32'd0, 4'd0, 4'd15);
        drive_request(MODE_SIGNED, -32'd42, 4'd0, 4'd6);
        // fixed point: clamp, zero decimals, leading fraction zeros, saturated width
        drive_request(MODE_FIXED, -32'd12345, 4'd2, 4'd0);
        drive_request(MODE_FIXED, 32'd123456, 4'd15, 4'd0);
        drive_request(MODE_FIXED, 32'd123456, 4'd5, 4'd8);
        drive_request(MODE_FIXED, -32'd987, 4'd0, 4'd15);
        drive_request(MODE_FIXED, 32'd5, 4'd4, 4'd0);
        drive_request(MODE_FIXED, 32'd0, 4'd4, 4'd0);
        drive_request(MODE_FIXED, 32'h8000_0000, 4'd4, 4'd15);
        drive_request(MODE_FIXED, 32'hFFFF_FFFF, 4'd4, 4'd13);
        drive_request(MODE_FIXED, 32'h7FFF_FFFF, 4'd3, 4'd14);
        drive_request(MODE_FIXED, 32'h8000_0000, 4'd0, 4'd0);
        // mode three behaves as fixed point
        drive_request(MODE_FIXED_ALT, -32'd31416, 4'd4, 4'd10);
        drive_request(MODE_FIXED_ALT, 32'h8000_0000, 4'd15, 4'd15);
        drive_request(MODE_FIXED_ALT, 32'd7, 4'd1, 4'd2);

        for (i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM / 3) hold_off_req = 1'b1;
            drive_request(2'($urandom_range(0, 3)), pick_value(),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
        s_valid <= 1'b0;

        while (sb.expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_chars.size() != 0) begin
            $error("%0d characters never arrived", sb.expected_chars.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
